// ----- rtl/lds_pkg.sv -----
package lds_pkg;

   localparam int WIDTH = 32;
   localparam int OUT_W = 64;
   // Bezout coefficients stay within the larger operand in magnitude, plus sign and margin.
   localparam int CW = WIDTH + 2;
   localparam int LZW = $clog2(WIDTH + 1);
   localparam int CNTW = $clog2(WIDTH);
   localparam int PCW = 4;

   typedef logic [PCW-1:0] pc_type;

   typedef enum logic [1:0] {
      STATUS_SOLVED       = 2'd0,
      STATUS_NO_SOLUTION  = 2'd1,
      STATUS_ZERO_OPERAND = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_ALIGN_E,
      OP_STEP_E,
      OP_UPDATE,
      OP_ALIGN_C,
      OP_STEP_C,
      OP_DONE
   } uop_type;

   typedef enum logic [2:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_START,
      JMP_R1_ZERO,
      JMP_CNT_NZ,
      JMP_REM_NZ
   } jump_type;

   typedef struct packed {
      uop_type    op;
      jump_type   jump;
      status_type status;
      pc_type     target;
   } ucode_type;

   localparam pc_type PC_IDLE   = 4'd0;
   localparam pc_type PC_CHKZ   = 4'd1;
   localparam pc_type PC_LOOP   = 4'd2;
   localparam pc_type PC_DIV    = 4'd3;
   localparam pc_type PC_UPD    = 4'd4;
   localparam pc_type PC_GCD    = 4'd5;
   localparam pc_type PC_CDIV   = 4'd6;
   localparam pc_type PC_CHKREM = 4'd7;
   localparam pc_type PC_SOLVED = 4'd8;
   localparam pc_type PC_NOSOL  = 4'd9;
   localparam pc_type PC_EZERO  = 4'd10;

   // Control store. A step runs its operation, then jumps to target when its
   // condition holds and otherwise falls through to the next step.
   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_IDLE:   w = '{OP_LOAD,    JMP_NO_START, STATUS_SOLVED,       PC_IDLE};
         PC_CHKZ:   w = '{OP_NOP,     JMP_R1_ZERO,  STATUS_SOLVED,       PC_EZERO};
         PC_LOOP:   w = '{OP_ALIGN_E, JMP_R1_ZERO,  STATUS_SOLVED,       PC_GCD};
         PC_DIV:    w = '{OP_STEP_E,  JMP_CNT_NZ,   STATUS_SOLVED,       PC_DIV};
         PC_UPD:    w = '{OP_UPDATE,  JMP_ALWAYS,   STATUS_SOLVED,       PC_LOOP};
         PC_GCD:    w = '{OP_ALIGN_C, JMP_NEVER,    STATUS_SOLVED,       PC_IDLE};
         PC_CDIV:   w = '{OP_STEP_C,  JMP_CNT_NZ,   STATUS_SOLVED,       PC_CDIV};
         PC_CHKREM: w = '{OP_NOP,     JMP_REM_NZ,   STATUS_SOLVED,       PC_NOSOL};
         PC_SOLVED: w = '{OP_DONE,    JMP_ALWAYS,   STATUS_SOLVED,       PC_IDLE};
         PC_NOSOL:  w = '{OP_DONE,    JMP_ALWAYS,   STATUS_NO_SOLUTION,  PC_IDLE};
         PC_EZERO:  w = '{OP_DONE,    JMP_ALWAYS,   STATUS_ZERO_OPERAND, PC_IDLE};
         default:   w = '{OP_NOP,     JMP_ALWAYS,   STATUS_SOLVED,       PC_IDLE};
      endcase
      return w;
   endfunction

   // Number of leading zeros of a WIDTH-bit word; WIDTH for zero.
   function automatic logic [LZW-1:0] lead_zeros(input logic [WIDTH-1:0] v);
      logic [LZW-1:0] n;
      n = LZW'(WIDTH);
      for (int i = 0; i < WIDTH; i++) begin
         if (v[i]) begin
            n = LZW'(WIDTH - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/linear_diophantine_solver.sv -----
// Solves a*x + b*y = c with the extended Euclidean algorithm.
// A request (req_coef_a, req_coef_b, req_target_c) is taken at a rising edge
// where start is high and busy is low. busy stays high until the result is out.
// Exactly one result follows each request: rsp_strobe is high for one cycle with
// rsp_sol_x, rsp_sol_y, rsp_divisor_g and rsp_status. The receiver cannot stall,
// so the result must be captured in that cycle; a new request may be issued in
// the same cycle the strobe is high.
// A small microcoded sequencer drives one shift-subtract divider that produces
// one quotient bit per cycle, starting at the aligned top bit. The same divider
// steps also accumulate quotient times coefficient, so no multiplier is used.
// Each Euclid step aligns the divisor by its alignment shift, the drop in bit length
// from dividend to divisor, runs the divider down to the last quotient bit and then
// updates the remainders and coefficients; the final c / gcd division is aligned and
// run the same way before its remainder is checked. A zero operand is answered
// before the Euclid loop starts. Reset returns the sequencer to idle and drops any
// request in progress; no result is issued for it.
module linear_diophantine_solver
   import lds_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [WIDTH-2:0]        req_coef_a,
   input  logic [WIDTH-2:0]        req_coef_b,
   input  logic signed [WIDTH-1:0] req_target_c,
   output logic                    rsp_strobe,
   output logic signed [OUT_W-1:0] rsp_sol_x,
   output logic signed [OUT_W-1:0] rsp_sol_y,
   output logic [WIDTH-2:0]        rsp_divisor_g,
   output logic [1:0]              rsp_status
);

   pc_type pc_ff, pc_in;
   ucode_type uw;

   logic [WIDTH-2:0] r0_ff, r0_in, r1_ff, r1_in;
   logic signed [CW-1:0] s0_ff, s0_in, s1_ff, s1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic [WIDTH-1:0] rem_ff, rem_in, dvs_ff, dvs_in, cmag_ff, cmag_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [OUT_W-1:0] px_ff, px_in, py_ff, py_in;
   logic a_larger_ff, a_larger_in, cneg_ff, cneg_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic [OUT_W-1:0] sol_x_ff, sol_x_in, sol_y_ff, sol_y_in;
   logic [WIDTH-2:0] gcd_ff, gcd_in;
   status_type status_ff, status_in;

   logic take;
   logic ge;
   logic [WIDTH-1:0] dvd_e, dvr_e, dvr_c;
   logic [LZW-1:0] lz_dvd_e, lz_dvr_e, lz_dvd_c, lz_dvr_c;
   logic [CNTW-1:0] k_e, k_c;
   logic [OUT_W-1:0] mul_s, mul_t, px_neg, py_neg, xs, ys;

   assign uw = ucode_rom(pc_ff);

   always_comb begin
      case (uw.jump)
         JMP_NEVER:    take = 1'b0;
         JMP_ALWAYS:   take = 1'b1;
         JMP_NO_START: take = !start;
         JMP_R1_ZERO:  take = (r1_ff == '0);
         JMP_CNT_NZ:   take = (cnt_ff != '0);
         JMP_REM_NZ:   take = (rem_ff != '0);
         default:      take = 1'b1;
      endcase
      pc_in = take ? uw.target : pc_ff + pc_type'(1);
   end

   // Alignment: the divisor is shifted up so its top bit meets the dividend's.
   assign dvd_e    = {1'b0, r0_ff};
   assign dvr_e    = {1'b0, r1_ff};
   assign dvr_c    = {1'b0, r0_ff};
   assign lz_dvd_e = lead_zeros(dvd_e);
   assign lz_dvr_e = lead_zeros(dvr_e);
   assign lz_dvd_c = lead_zeros(cmag_ff);
   assign lz_dvr_c = lead_zeros(dvr_c);
   assign k_e = (lz_dvr_e > lz_dvd_e) ? CNTW'(lz_dvr_e - lz_dvd_e) : '0;
   assign k_c = (lz_dvr_c > lz_dvd_c) ? CNTW'(lz_dvr_c - lz_dvd_c) : '0;

   assign ge = (rem_ff >= dvs_ff);

   // Euclid steps accumulate q * s1 and q * t1; the final division
   // accumulates (c / g) * s0 and (c / g) * t0.
   always_comb begin
      if (uw.op == OP_STEP_C) begin
         mul_s = {{(OUT_W-CW){s0_ff[CW-1]}}, s0_ff};
         mul_t = {{(OUT_W-CW){t0_ff[CW-1]}}, t0_ff};
      end else begin
         mul_s = {{(OUT_W-CW){s1_ff[CW-1]}}, s1_ff};
         mul_t = {{(OUT_W-CW){t1_ff[CW-1]}}, t1_ff};
      end
   end

   assign px_neg = '0 - px_ff;
   assign py_neg = '0 - py_ff;
   assign xs = cneg_ff ? px_neg : px_ff;
   assign ys = cneg_ff ? py_neg : py_ff;

   always_comb begin
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      cmag_in       = cmag_ff;
      a_larger_in   = a_larger_ff;
      cneg_in       = cneg_ff;
      rsp_strobe_in = 1'b0;
      sol_x_in      = sol_x_ff;
      sol_y_in      = sol_y_ff;
      gcd_in        = gcd_ff;
      status_in     = status_ff;
      case (uw.op)
         OP_LOAD: begin
            a_larger_in = req_coef_a > req_coef_b;
            r0_in       = (req_coef_a > req_coef_b) ? req_coef_a : req_coef_b;
            r1_in       = (req_coef_a > req_coef_b) ? req_coef_b : req_coef_a;
            s0_in       = CW'(1);
            s1_in       = '0;
            t0_in       = '0;
            t1_in       = CW'(1);
            cneg_in     = req_target_c[WIDTH-1];
            cmag_in     = req_target_c[WIDTH-1] ? ('0 - $unsigned(req_target_c))
                                                : $unsigned(req_target_c);
         end
         OP_ALIGN_E: begin
            rem_in = dvd_e;
            dvs_in = dvr_e << k_e;
            cnt_in = k_e;
            px_in  = '0;
            py_in  = '0;
         end
         OP_ALIGN_C: begin
            rem_in = cmag_ff;
            dvs_in = dvr_c << k_c;
            cnt_in = k_c;
            px_in  = '0;
            py_in  = '0;
         end
         OP_STEP_E, OP_STEP_C: begin
            rem_in = ge ? rem_ff - dvs_ff : rem_ff;
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNTW'(1);
            px_in  = {px_ff[OUT_W-2:0], 1'b0} + (ge ? mul_s : '0);
            py_in  = {py_ff[OUT_W-2:0], 1'b0} + (ge ? mul_t : '0);
         end
         OP_UPDATE: begin
            r0_in = r1_ff;
            r1_in = rem_ff[WIDTH-2:0];
            s0_in = s1_ff;
            s1_in = s0_ff - $signed(px_ff[CW-1:0]);
            t0_in = t1_ff;
            t1_in = t0_ff - $signed(py_ff[CW-1:0]);
         end
         OP_DONE: begin
            rsp_strobe_in = 1'b1;
            status_in     = uw.status;
            gcd_in        = (uw.status == STATUS_ZERO_OPERAND) ? '0 : r0_ff;
            if (uw.status == STATUS_SOLVED) begin
               sol_x_in = a_larger_ff ? xs : ys;
               sol_y_in = a_larger_ff ? ys : xs;
            end else begin
               sol_x_in = '0;
               sol_y_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= PC_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      r0_ff       <= r0_in;
      r1_ff       <= r1_in;
      s0_ff       <= s0_in;
      s1_ff       <= s1_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      cnt_ff      <= cnt_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      cmag_ff     <= cmag_in;
      a_larger_ff <= a_larger_in;
      cneg_ff     <= cneg_in;
      sol_x_ff    <= sol_x_in;
      sol_y_ff    <= sol_y_in;
      gcd_ff      <= gcd_in;
      status_ff   <= status_in;
   end

   assign busy          = (pc_ff != PC_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_sol_x     = $signed(sol_x_ff);
   assign rsp_sol_y     = $signed(sol_y_ff);
   assign rsp_divisor_g = gcd_ff;
   assign rsp_status    = status_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result issued while sequencer not idle");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_ZERO_OPERAND) |-> (rsp_divisor_g == '0))
      else $error("zero operand result carries a nonzero gcd");

   a_unsolved_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STATUS_SOLVED) |-> (rsp_sol_x == '0 && rsp_sol_y == '0))
      else $error("unsolved result carries a nonzero pair");

endmodule

// ----- tb/lds_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the solver, works out the expected solution for each
// accepted request and compares every strobed result against the oldest one.
module lds_checker
   import lds_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [WIDTH-2:0]        req_coef_a,
   input  logic [WIDTH-2:0]        req_coef_b,
   input  logic signed [WIDTH-1:0] req_target_c,
   input  logic                    rsp_strobe,
   input  logic signed [OUT_W-1:0] rsp_sol_x,
   input  logic signed [OUT_W-1:0] rsp_sol_y,
   input  logic [WIDTH-2:0]        rsp_divisor_g,
   input  logic [1:0]              rsp_status,
   output int                      mismatch_count,
   output int                      outstanding
);

   typedef struct {
      logic signed [OUT_W-1:0] x;
      logic signed [OUT_W-1:0] y;
      logic [WIDTH-2:0]        g;
      status_type              status;
   } solution_type;

   solution_type pending_solutions[$];

   // Extended Euclid on the larger and smaller coefficient, then the Bezout pair is
   // scaled by c / gcd. All arithmetic wraps modulo 2^OUT_W.
   function automatic solution_type solve_equation(input logic [WIDTH-2:0] a,
                                                   input logic [WIDTH-2:0] b,
                                                   input logic signed [WIDTH-1:0] c);
      solution_type sol;
      logic a_larger;
      logic [OUT_W-1:0] r0, r1, s0, s1, t0, t1, quo, nr, ns, nt, c_mag, mult;
      logic signed [OUT_W-1:0] c_ext;
      sol.x = '0;
      sol.y = '0;
      sol.g = '0;
      sol.status = STATUS_SOLVED;
      if (a == '0 || b == '0) begin
         sol.status = STATUS_ZERO_OPERAND;
         return sol;
      end
      // On a tie, a is treated as the smaller operand.
      a_larger = a > b;
      r0 = a_larger ? OUT_W'(a) : OUT_W'(b);
      r1 = a_larger ? OUT_W'(b) : OUT_W'(a);
      s0 = 1;
      s1 = 0;
      t0 = 0;
      t1 = 1;
      while (r1 != 0) begin
         quo = r0 / r1;
         nr = r0 - quo * r1;
         ns = s0 - quo * s1;
         nt = t0 - quo * t1;
         r0 = r1;
         r1 = nr;
         s0 = s1;
         s1 = ns;
         t0 = t1;
         t1 = nt;
      end
      sol.g = r0[WIDTH-2:0];
      c_ext = OUT_W'(c);
      c_mag = (c_ext < 0) ? -c_ext : c_ext;
      if (c_mag % r0 != 0) begin
         sol.status = STATUS_NO_SOLUTION;
         return sol;
      end
      mult = c_mag / r0;
      if (c_ext < 0) begin
         mult = '0 - mult;
      end
      // s0 belongs to the larger operand, t0 to the smaller one.
      if (a_larger) begin
         sol.x = s0 * mult;
         sol.y = t0 * mult;
      end else begin
         sol.x = t0 * mult;
         sol.y = s0 * mult;
      end
      return sol;
   endfunction

   always @(posedge clock) begin
      solution_type expected;
      if (reset) begin
         pending_solutions.delete();
         mismatch_count = 0;
      end else begin
         // A result strobed at the same edge as a new request belongs to an older
         // request, so the result is matched before the new request is queued.
         if (rsp_strobe) begin
            if (pending_solutions.size() == 0) begin
               $error("result with no request outstanding: x=%0d y=%0d g=%0d status=%0d",
                      rsp_sol_x, rsp_sol_y, rsp_divisor_g, rsp_status);
               mismatch_count++;
            end else begin
               expected = pending_solutions.pop_front();
               if (rsp_sol_x !== expected.x) begin
                  $error("sol_x: expected %0d, got %0d", expected.x, rsp_sol_x);
                  mismatch_count++;
               end
               if (rsp_sol_y !== expected.y) begin
                  $error("sol_y: expected %0d, got %0d", expected.y, rsp_sol_y);
                  mismatch_count++;
               end
               if (rsp_divisor_g !== expected.g) begin
                  $error("divisor_g: expected %0d, got %0d", expected.g, rsp_divisor_g);
                  mismatch_count++;
               end
               if (rsp_status !== expected.status) begin
                  $error("status: expected %0d, got %0d", expected.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            pending_solutions.insert(pending_solutions.size(),
               solve_equation(req_coef_a, req_coef_b, req_target_c));
         end
      end
      outstanding = pending_solutions.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top
   import lds_pkg::*;
();

   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [WIDTH-2:0] COEF_MAX = '1;
   localparam logic signed [WIDTH-1:0] C_MAX = {1'b0, {(WIDTH-1){1'b1}}};
   localparam logic signed [WIDTH-1:0] C_MIN = {1'b1, {(WIDTH-1){1'b0}}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [WIDTH-2:0]        req_coef_a = '0;
   logic [WIDTH-2:0]        req_coef_b = '0;
   logic signed [WIDTH-1:0] req_target_c = '0;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_sol_x;
   logic signed [OUT_W-1:0] rsp_sol_y;
   logic [WIDTH-2:0]        rsp_divisor_g;
   logic [1:0]              rsp_status;
   int                      mismatch_count;
   int                      outstanding;
   int                      stall_cycles = 0;
   logic                    idle_enable = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   linear_diophantine_solver u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_coef_a    (req_coef_a),
      .req_coef_b    (req_coef_b),
      .req_target_c  (req_target_c),
      .rsp_strobe    (rsp_strobe),
      .rsp_sol_x     (rsp_sol_x),
      .rsp_sol_y     (rsp_sol_y),
      .rsp_divisor_g (rsp_divisor_g),
      .rsp_status    (rsp_status)
   );

   lds_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_coef_a     (req_coef_a),
      .req_coef_b     (req_coef_b),
      .req_target_c   (req_target_c),
      .rsp_strobe     (rsp_strobe),
      .rsp_sol_x      (rsp_sol_x),
      .rsp_sol_y      (rsp_sol_y),
      .rsp_divisor_g  (rsp_divisor_g),
      .rsp_status     (rsp_status),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Ends the run when neither a request nor a result has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Holds the request until it is taken. On idle cycles start drops and the
   // request fields carry noise.
   task automatic issue_request(input logic [WIDTH-2:0] a, input logic [WIDTH-2:0] b,
                                input logic signed [WIDTH-1:0] c);
      logic taken;
      taken = 1'b0;
      while (!taken) begin
         if (idle_enable && $urandom_range(99) < 14) begin
            start <= 1'b0;
            req_coef_a <= (WIDTH-1)'($urandom());
            req_coef_b <= (WIDTH-1)'($urandom());
            req_target_c <= $urandom();
         end else begin
            start <= 1'b1;
            req_coef_a <= a;
            req_coef_b <= b;
            req_target_c <= c;
         end
         @(posedge clock);
         taken = start && !busy;
      end
   endtask

   // Stops sending until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_request();
      logic [WIDTH-2:0] a, b, swap;
      logic signed [WIDTH-1:0] c;
      int unsigned pick, factor;
      int scale;
      pick = $urandom_range(99);
      a = (WIDTH-1)'($urandom());
      b = (WIDTH-1)'($urandom());
      c = $urandom();
      if (pick < 35) begin
         // Fully random operands, coprime more often than not.
      end else if (pick < 60) begin
         // Shared factor, with c a multiple of it about half of the time.
         factor = $urandom_range(32767, 1);
         a = (WIDTH-1)'(factor * $urandom_range(65535, 1));
         b = (WIDTH-1)'(factor * $urandom_range(65535, 1));
         if ($urandom_range(1) == 1) begin
            scale = int'($urandom_range(131071)) - 65536;
            c = int'(factor) * scale;
         end
      end else if (pick < 70) begin
         a = (WIDTH-1)'($urandom_range(15));
         b = (WIDTH-1)'($urandom_range(15));
         c = int'($urandom_range(63)) - 32;
      end else if (pick < 80) begin
         // The smaller operand divides the larger one.
         b = (WIDTH-1)'($urandom_range(65535, 1));
         a = (WIDTH-1)'(b * $urandom_range(32767, 1));
         if ($urandom_range(1) == 1) begin
            swap = a;
            a = b;
            b = swap;
         end
      end else if (pick < 88) begin
         b = a;
      end else if (pick < 95) begin
         case ($urandom_range(2))
            0: a = '0;
            1: b = '0;
            default: begin
               a = '0;
               b = '0;
            end
         endcase
      end else begin
         if ($urandom_range(1) == 1) a = COEF_MAX;
         if ($urandom_range(1) == 1) b = ($urandom_range(1) == 1) ? COEF_MAX : (WIDTH-1)'(1);
         case ($urandom_range(2))
            0: c = C_MAX;
            1: c = C_MIN;
            default: c = '0;
         endcase
      end
      issue_request(a, b, c);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Zero operands.
      issue_request(0, 0, 0);
      issue_request(0, 5, 7);
      issue_request(9, 0, -3);
      issue_request(0, COEF_MAX, C_MIN);
      // Extremes, equal operands and unit operands.
      issue_request(COEF_MAX, COEF_MAX, C_MAX);
      issue_request(1, 1, C_MIN);
      issue_request(COEF_MAX, 1, C_MIN);
      issue_request(1, COEF_MAX, C_MAX);
      issue_request(7, 7, 21);
      issue_request(7, 7, 22);
      // No solution, then a solvable c for the same pair.
      issue_request(6, 4, 5);
      issue_request(6, 4, -10);
      // The smaller operand divides the larger one, on either side.
      issue_request(12, 4, 8);
      issue_request(4, 12, -8);
      // Consecutive Fibonacci numbers give the longest Euclid chain.
      issue_request(1836311903, 1134903170, -1);
      issue_request(1134903170, 1836311903, C_MAX);
      issue_request(COEF_MAX, COEF_MAX - 1'b1, C_MIN);
      issue_request(31'h4000_0000, 31'h2000_0000, C_MIN);
      issue_request(31'h4000_0000, 31'h3000_0000, 32'sh1000_0001);
      issue_request(35, 15, 0);
      issue_request(31'h2AAA_AAAA, 31'h5555_5555, 32'shAAAA_AAAA);
      issue_request(1, 2, -1);
      drain_results();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_enable = !(n >= 500 && n < 700);
         if (n == 900) begin
            drain_results();
         end
         random_request();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
